// ===== rtl/mcmw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mcmw_pkg;

  // channel bank size
  localparam int CHANNELS = 6;

  localparam int NOW_W    = 32;
  localparam int PERIOD_W = 16;
  // period times five fits in three more bits
  localparam int LIMIT_W  = PERIOD_W + 3;
  localparam int TIMEOUT_FACTOR = 5;

  localparam int CH_W      = 3;
  localparam int COUNT_W   = 3;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK    = 2'd0,
    MODE_REFRESH = 2'd1,
    MODE_CHECK   = 2'd2
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_IN_USE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_FIRST    = 3'd1;

  typedef logic [CHANNELS-1:0][PERIOD_W-1:0] period_arr_t;

  typedef struct packed {
    logic [NOW_W-1:0]                now_ms;
    logic [CHANNELS-1:0][NOW_W-1:0]  last_refresh;
    logic [CHANNELS-1:0]             timeout_flags;
  } wd_state_t;

endpackage

`default_nettype wire

// ===== rtl/mcmw_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mcmw_item_if;
  logic                           valid;
  logic                           ready;
  logic [mcmw_pkg::MODE_W-1:0]    mode;
  logic [mcmw_pkg::CH_W-1:0]      channel;

  modport source (output valid, output mode, output channel, input ready);
  modport sink   (input valid, input mode, input channel, output ready);
endinterface

interface mcmw_result_if;
  logic                           valid;
  logic                           ready;
  logic [mcmw_pkg::CHANNELS-1:0]  error_flags;
  logic                           any_error;

  modport source (output valid, output error_flags, output any_error, input ready);
  modport sink   (input valid, input error_flags, input any_error, output ready);
endinterface

interface mcmw_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mcmw_pkg::CFG_IDX_W-1:0]   index;
  logic [mcmw_pkg::CFG_DAT_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/mcmw_update.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mcmw_update (
  input  mcmw_pkg::mode_t                    mode,
  input  logic [mcmw_pkg::CH_W-1:0]          channel,
  input  logic [mcmw_pkg::COUNT_W-1:0]       channels_in_use,
  input  mcmw_pkg::period_arr_t              periods,
  input  mcmw_pkg::wd_state_t                cur,
  output mcmw_pkg::wd_state_t                nxt,
  output logic                               any_error
);

  logic [mcmw_pkg::COUNT_W-1:0]   enabled_n;
  logic [mcmw_pkg::CHANNELS-1:0]  enabled;
  logic [mcmw_pkg::CHANNELS-1:0]  expired;

  // clamp the enabled count to the bank size
  always_comb begin
    if (channels_in_use > mcmw_pkg::COUNT_W'(mcmw_pkg::CHANNELS)) begin
      enabled_n = mcmw_pkg::COUNT_W'(mcmw_pkg::CHANNELS);
    end else begin
      enabled_n = channels_in_use;
    end
  end

  // per channel: enable, wrapped elapsed time against five periods
  always_comb begin
    logic [mcmw_pkg::NOW_W-1:0]   elapsed;
    logic [mcmw_pkg::LIMIT_W-1:0] limit;
    for (int c = 0; c < mcmw_pkg::CHANNELS; c++) begin
      enabled[c] = mcmw_pkg::COUNT_W'(c) < enabled_n;
      elapsed    = cur.now_ms - cur.last_refresh[c];
      limit      = {periods[c], 2'b00} + mcmw_pkg::LIMIT_W'(periods[c]);
      expired[c] = elapsed >= mcmw_pkg::NOW_W'(limit);
    end
  end

  always_comb begin
    nxt = cur;
    case (mode)
      mcmw_pkg::MODE_TICK: begin
        nxt.now_ms = cur.now_ms + mcmw_pkg::NOW_W'(1);
      end
      mcmw_pkg::MODE_REFRESH: begin
        for (int c = 0; c < mcmw_pkg::CHANNELS; c++) begin
          if (channel == mcmw_pkg::CH_W'(c) && enabled[c]) begin
            nxt.last_refresh[c] = cur.now_ms;
          end
        end
      end
      mcmw_pkg::MODE_CHECK: begin
        for (int c = 0; c < mcmw_pkg::CHANNELS; c++) begin
          if (enabled[c]) begin
            nxt.timeout_flags[c] = expired[c];
          end
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  assign any_error = |(nxt.timeout_flags & enabled);

endmodule

`default_nettype wire

// ===== rtl/multi_channel_message_watchdog_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// bank of six message watchdogs sharing one millisecond count that tick beats advance.
// each input beat is a tick (count plus one, wrapping at 2^32), a refresh of
// one enabled channel (stamps it with the current count; channels at or above
// the enabled count are ignored) or a check (every enabled channel's flag is
// set when the wrapped time since its last refresh reaches five periods, and
// cleared otherwise). every input beat gives exactly one result beat with the
// flag vector and the or of the enabled channels' flags, taken after the
// update. an item passes through the input register and then the result
// register, and one item is taken per cycle while the result register is not
// stalled; the only limit on rate is the single-entry result register.
// configuration writes are always accepted and must happen while idle.
module multi_channel_message_watchdog_core (
  input  logic                 clk,
  input  logic                 rst,
  mcmw_item_if.sink            item,
  mcmw_result_if.source        result,
  mcmw_cfg_if.sink             cfg
);

  // configuration registers
  logic [mcmw_pkg::COUNT_W-1:0] channels_in_use;
  mcmw_pkg::period_arr_t        periods;

  // watchdog state: counter, stamps and flags
  mcmw_pkg::wd_state_t          state;
  mcmw_pkg::wd_state_t          state_next;
  logic                         any_next;

  // input register
  logic                         s1_valid;
  mcmw_pkg::mode_t              s1_mode;
  logic [mcmw_pkg::CH_W-1:0]    s1_channel;
  logic                         s1_fire;

  // result register
  logic                         out_valid;
  logic [mcmw_pkg::CHANNELS-1:0] out_flags;
  logic                         out_any;

  // the input register moves on whenever the result slot is free or draining
  assign s1_fire    = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || !out_valid || result.ready;

  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channels_in_use <= '0;
      periods         <= '0;
    end else if (cfg.valid) begin
      if (cfg.index == mcmw_pkg::REG_CHANNELS_IN_USE) begin
        channels_in_use <= cfg.data[mcmw_pkg::COUNT_W-1:0];
      end
      for (int c = 0; c < mcmw_pkg::CHANNELS; c++) begin
        if (cfg.index == mcmw_pkg::CFG_IDX_W'(int'(mcmw_pkg::REG_PERIOD_FIRST) + c)) begin
          periods[c] <= cfg.data[mcmw_pkg::PERIOD_W-1:0];
        end
      end
    end
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_mode    <= mcmw_pkg::mode_t'(item.mode);
      s1_channel <= item.channel;
    end
  end

  mcmw_update u_update (
    .mode            (s1_mode),
    .channel         (s1_channel),
    .channels_in_use (channels_in_use),
    .periods         (periods),
    .cur             (state),
    .nxt             (state_next),
    .any_error       (any_next)
  );

  // state commits as the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_flags <= state_next.timeout_flags;
      out_any   <= any_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.error_flags = out_flags;
  assign result.any_error   = out_any;

endmodule

`default_nettype wire
